// ===== sv/rhythm_sample_voice_mixer_defines.svh =====
// Assertion macros shared by the drum voice mixer modules.
`ifndef RHYTHM_SAMPLE_VOICE_MIXER_DEFINES_SVH
`define RHYTHM_SAMPLE_VOICE_MIXER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define RSVM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RSVM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/rsvm_pkg.sv =====
// Shared types, codes and the gain table of the drum voice mixer.
package rsvm_pkg;

   localparam int NVOICES = 6;
   localparam int DRAIN_CYCLES = 3;

   // Beat kinds on the request channel.
   localparam logic [1:0] KIND_REG   = 2'd0;
   localparam logic [1:0] KIND_TICK  = 2'd1;
   localparam logic [1:0] KIND_MEM   = 2'd2;
   localparam logic [1:0] KIND_SETUP = 2'd3;

   // Rhythm register addresses.
   localparam logic [7:0] ADDR_KEY      = 8'h10;
   localparam logic [7:0] ADDR_TOTAL    = 8'h11;
   localparam logic [7:0] ADDR_PAN_BASE = 8'h18;

   localparam int DB_MIN = -31;
   localparam int DB_MAX = 127;
   localparam int GAIN_ENTRIES = 159;

   // 2^(k/8) scaled by 2^32.
   localparam logic [32:0] ROOT8 [8] = '{
      33'd4294967296, 33'd4683695047, 33'd5107605667, 33'd5569883475,
      33'd6074000999, 33'd6623744058, 33'd7223245205, 33'd7877004751
   };

   typedef logic [15:0] gain_rom_type [GAIN_ENTRIES];

   // Gain for attenuation db = index + DB_MIN, already shifted right by four.
   function automatic gain_rom_type gain_rom_init();
      gain_rom_type rom;
      logic [7:0]   t;
      logic [63:0]  x;
      for (int i = 0; i < GAIN_ENTRIES; i++) begin
         t = 8'(128 - DB_MIN - i);
         x = 64'(ROOT8[t[2:0]]) << t[7:3];
         x = x >> 32;
         rom[i] = 16'((x - 64'd1) >> 4);
      end
      return rom;
   endfunction

   localparam gain_rom_type GAIN_ROM = gain_rom_init();

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_DONE
   } rsvm_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       accept;
      logic       issue;
      logic [2:0] voice;
      logic       out_load;
   } rsvm_cmd_type;

endpackage

// ===== sv/rsvm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rsvm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/rsvm_ctrl.sv =====
// Controller that sequences the six voices of an output tick.
`include "rhythm_sample_voice_mixer_defines.svh"

module rsvm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_kind,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsvm_pkg::rsvm_cmd_type cmd
);

   rsvm_pkg::rsvm_state_type state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // State, step counter and output valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsvm_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.voice    = cnt_ff;
      unique case (state_ff)
         rsvm_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && req_kind == rsvm_pkg::KIND_TICK) begin
               state_in = rsvm_pkg::ST_ISSUE;
               cnt_in   = '0;
            end
         end
         rsvm_pkg::ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (cnt_ff == 3'(rsvm_pkg::NVOICES - 1)) begin
               state_in = rsvm_pkg::ST_DRAIN;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         rsvm_pkg::ST_DRAIN: begin
            if (cnt_ff == 3'(rsvm_pkg::DRAIN_CYCLES - 1)) begin
               state_in = rsvm_pkg::ST_DONE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         rsvm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = rsvm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rsvm_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `RSVM_ASSERT_NEXT(a_tick_starts_issue, clock, reset, (req_valid && req_ready && req_kind == rsvm_pkg::KIND_TICK), (state_ff == rsvm_pkg::ST_ISSUE && cnt_ff == 3'd0), "tick beat did not start voice issue")
   `RSVM_ASSERT_NEXT(a_last_voice_drains, clock, reset, (state_ff == rsvm_pkg::ST_ISSUE && cnt_ff == 3'(rsvm_pkg::NVOICES - 1)), (state_ff == rsvm_pkg::ST_DRAIN), "issue did not stop after the last voice")
   `RSVM_ASSERT_NOW(a_load_when_free, clock, reset, cmd.out_load, (!rsp_valid_ff || rsp_ready), "result loaded over an untaken result")
   `RSVM_ASSERT_NOW(a_no_issue_on_accept, clock, reset, cmd.issue, (!cmd.accept && cmd.voice < 3'(rsvm_pkg::NVOICES)), "voice issue overlaps a request beat")

endmodule

// ===== sv/rsvm_datapath.sv =====
// Voice state, sample memory and the four-stage scale and mix pipeline.
`include "rhythm_sample_voice_mixer_defines.svh"

module rsvm_datapath #(
   parameter int VOICE_SAMPLES = 65536,
   parameter int FRACTION_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rsvm_pkg::rsvm_cmd_type cmd,
   input  logic [1:0]             req_kind,
   input  logic [7:0]             req_reg_addr,
   input  logic [7:0]             req_reg_data,
   input  logic [2:0]             req_voice,
   input  logic [15:0]            req_mem_addr,
   input  logic signed [15:0]     req_mem_sample,
   input  logic [16:0]            req_voice_length,
   input  logic [15:0]            req_voice_step,
   input  logic signed [7:0]      req_voice_volume,
   input  logic signed [15:0]     req_in_left,
   input  logic signed [15:0]     req_in_right,
   output logic signed [15:0]     rsp_out_left,
   output logic signed [15:0]     rsp_out_right
);

   localparam int AW       = $clog2(VOICE_SAMPLES);
   localparam int LEN_W    = $clog2(VOICE_SAMPLES + 1);
   localparam int END_W    = LEN_W + FRACTION_BITS;
   localparam int POS_W    = ((END_W > 16) ? END_W : 16) + 1;
   localparam int RAM_DEPTH = rsvm_pkg::NVOICES * (2 ** AW);
   localparam int RAM_AW   = $clog2(RAM_DEPTH);

   // Per-voice state.
   logic [5:0]          key_mask_ff, key_mask_in;
   logic [5:0]          total_level_ff, total_level_in;
   logic                present_ff, present_in;
   logic [1:0]          pan_ff [rsvm_pkg::NVOICES];
   logic [1:0]          pan_in [rsvm_pkg::NVOICES];
   logic [4:0]          level_ff [rsvm_pkg::NVOICES];
   logic [4:0]          level_in [rsvm_pkg::NVOICES];
   logic signed [7:0]   offset_ff [rsvm_pkg::NVOICES];
   logic signed [7:0]   offset_in [rsvm_pkg::NVOICES];
   logic [POS_W-1:0]    pos_ff [rsvm_pkg::NVOICES];
   logic [POS_W-1:0]    pos_in [rsvm_pkg::NVOICES];
   logic [END_W-1:0]    end_ff [rsvm_pkg::NVOICES];
   logic [END_W-1:0]    end_in [rsvm_pkg::NVOICES];
   logic [15:0]         inc_ff [rsvm_pkg::NVOICES];
   logic [15:0]         inc_in [rsvm_pkg::NVOICES];

   // Pipeline registers.
   logic                s1_play_ff, s1_play_in;
   logic [1:0]          s1_pan_ff, s1_pan_in;
   logic [7:0]          s1_idx_ff, s1_idx_in;
   logic                s2_play_ff, s2_play_in;
   logic [1:0]          s2_pan_ff, s2_pan_in;
   logic [15:0]         s2_gain_ff, s2_gain_in;
   logic signed [15:0]  s2_sample_ff, s2_sample_in;
   logic                s3_play_ff, s3_play_in;
   logic [1:0]          s3_pan_ff, s3_pan_in;
   logic signed [20:0]  s3_contrib_ff, s3_contrib_in;
   logic signed [15:0]  acc_left_ff, acc_left_in;
   logic signed [15:0]  acc_right_ff, acc_right_in;
   logic signed [15:0]  out_left_ff, out_left_in;
   logic signed [15:0]  out_right_ff, out_right_in;

   // Working signals.
   logic                play0;
   logic signed [9:0]   db_sum;
   logic [7:0]          db_idx;
   logic [AW-1:0]       rd_idx;
   logic [POS_W-FRACTION_BITS-1:0] pos_int;
   logic [LEN_W-1:0]    len_sat;
   logic                pan_hit;
   logic                voice_ok;
   logic                mem_wr_en;
   logic [RAM_AW-1:0]   mem_wr_addr;
   logic [RAM_AW-1:0]   mem_rd_addr;
   logic signed [15:0]  mem_rd_data;
   logic signed [32:0]  product;

   function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
      logic signed [15:0] r;
      if (v > 22'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -22'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = 16'(v);
      end
      return r;
   endfunction

   // Sample memory, one region per voice.
   rsvm_ram #(
      .WIDTH (16),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (req_mem_sample),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign voice_ok    = (req_voice < 3'(rsvm_pkg::NVOICES));
   assign mem_wr_en   = cmd.accept && (req_kind == rsvm_pkg::KIND_MEM) && voice_ok &&
                        (32'(req_mem_addr) < 32'(VOICE_SAMPLES));
   assign mem_wr_addr = {req_voice, AW'(req_mem_addr)};
   assign pan_hit     = (req_reg_addr[7:3] == rsvm_pkg::ADDR_PAN_BASE[7:3]) &&
                        (req_reg_addr[2:0] < 3'(rsvm_pkg::NVOICES));
   assign len_sat     = (32'(req_voice_length) > 32'(VOICE_SAMPLES)) ?
                        LEN_W'(VOICE_SAMPLES) : LEN_W'(req_voice_length);

   // Issue stage: voice check, attenuation index and memory address.
   assign play0   = present_ff && key_mask_ff[cmd.voice] &&
                    (pos_ff[cmd.voice] < POS_W'(end_ff[cmd.voice]));
   assign db_sum  = $signed({4'b0000, total_level_ff}) +
                    $signed({5'b00000, level_ff[cmd.voice]}) + 10'(offset_ff[cmd.voice]);
   assign pos_int = pos_ff[cmd.voice][POS_W-1:FRACTION_BITS];
   assign rd_idx  = (32'(pos_int) >= 32'(VOICE_SAMPLES)) ?
                    AW'(VOICE_SAMPLES - 1) : AW'(pos_int);
   assign mem_rd_addr = {cmd.voice, rd_idx};

   always_comb begin
      priority if (db_sum > 10'(rsvm_pkg::DB_MAX)) begin
         db_idx = 8'(rsvm_pkg::DB_MAX - rsvm_pkg::DB_MIN);
      end else if (db_sum < 10'(rsvm_pkg::DB_MIN)) begin
         db_idx = 8'd0;
      end else begin
         db_idx = 8'(db_sum - 10'(rsvm_pkg::DB_MIN));
      end
   end

   // Scale stage product.
   assign product = s2_sample_ff * $signed({1'b0, s2_gain_ff});

   // Next values of voice state, pipeline and accumulators.
   always_comb begin
      key_mask_in    = key_mask_ff;
      total_level_in = total_level_ff;
      present_in     = present_ff;
      pan_in         = pan_ff;
      level_in       = level_ff;
      offset_in      = offset_ff;
      pos_in         = pos_ff;
      end_in         = end_ff;
      inc_in         = inc_ff;
      acc_left_in    = acc_left_ff;
      acc_right_in   = acc_right_ff;
      out_left_in    = out_left_ff;
      out_right_in   = out_right_ff;

      // Request beats that change state.
      if (cmd.accept) begin
         unique case (req_kind)
            rsvm_pkg::KIND_REG: begin
               priority if (req_reg_addr == rsvm_pkg::ADDR_KEY) begin
                  if (!req_reg_data[7]) begin
                     key_mask_in = key_mask_ff | req_reg_data[5:0];
                     for (int i = 0; i < rsvm_pkg::NVOICES; i++) begin
                        if (req_reg_data[i]) begin
                           pos_in[i] = '0;
                        end
                     end
                  end else begin
                     key_mask_in = key_mask_ff & ~req_reg_data[5:0];
                  end
               end else if (req_reg_addr == rsvm_pkg::ADDR_TOTAL) begin
                  total_level_in = ~req_reg_data[5:0];
               end else if (pan_hit) begin
                  pan_in[req_reg_addr[2:0]]   = req_reg_data[7:6];
                  level_in[req_reg_addr[2:0]] = ~req_reg_data[4:0];
               end else begin
                  key_mask_in = key_mask_ff;
               end
            end
            rsvm_pkg::KIND_TICK: begin
               acc_left_in  = req_in_left;
               acc_right_in = req_in_right;
            end
            rsvm_pkg::KIND_MEM: begin
               present_in = present_ff;
            end
            rsvm_pkg::KIND_SETUP: begin
               if (voice_ok) begin
                  end_in[req_voice]    = {len_sat, {FRACTION_BITS{1'b0}}};
                  inc_in[req_voice]    = req_voice_step;
                  offset_in[req_voice] = req_voice_volume;
                  present_in           = 1'b1;
               end
            end
            default: begin
               present_in = present_ff;
            end
         endcase
      end

      // Advance the position of a voice that plays this tick.
      if (cmd.issue && play0) begin
         pos_in[cmd.voice] = pos_ff[cmd.voice] + POS_W'(inc_ff[cmd.voice]);
      end

      // Mix stage: saturating add per panned channel.
      if (s3_play_ff) begin
         if (s3_pan_ff[1]) begin
            acc_left_in = sat16(22'(acc_left_ff) + 22'(s3_contrib_ff));
         end
         if (s3_pan_ff[0]) begin
            acc_right_in = sat16(22'(acc_right_ff) + 22'(s3_contrib_ff));
         end
      end

      if (cmd.out_load) begin
         out_left_in  = acc_left_ff;
         out_right_in = acc_right_ff;
      end
   end

   // Pipeline stage inputs.
   assign s1_play_in    = cmd.issue && play0;
   assign s1_pan_in     = pan_ff[cmd.voice];
   assign s1_idx_in     = db_idx;
   assign s2_play_in    = s1_play_ff;
   assign s2_pan_in     = s1_pan_ff;
   assign s2_gain_in    = rsvm_pkg::GAIN_ROM[s1_idx_ff];
   assign s2_sample_in  = mem_rd_data;
   assign s3_play_in    = s2_play_ff;
   assign s3_pan_in     = s2_pan_ff;
   assign s3_contrib_in = product[32:12];

   // Control and voice state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_mask_ff    <= '0;
         total_level_ff <= '0;
         present_ff     <= 1'b0;
         s1_play_ff     <= 1'b0;
         s2_play_ff     <= 1'b0;
         s3_play_ff     <= 1'b0;
         for (int i = 0; i < rsvm_pkg::NVOICES; i++) begin
            pan_ff[i]    <= '0;
            level_ff[i]  <= '0;
            offset_ff[i] <= '0;
            pos_ff[i]    <= '1;
            end_ff[i]    <= '0;
            inc_ff[i]    <= '0;
         end
      end else begin
         key_mask_ff    <= key_mask_in;
         total_level_ff <= total_level_in;
         present_ff     <= present_in;
         s1_play_ff     <= s1_play_in;
         s2_play_ff     <= s2_play_in;
         s3_play_ff     <= s3_play_in;
         pan_ff         <= pan_in;
         level_ff       <= level_in;
         offset_ff      <= offset_in;
         pos_ff         <= pos_in;
         end_ff         <= end_in;
         inc_ff         <= inc_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_pan_ff     <= s1_pan_in;
      s1_idx_ff     <= s1_idx_in;
      s2_pan_ff     <= s2_pan_in;
      s2_gain_ff    <= s2_gain_in;
      s2_sample_ff  <= s2_sample_in;
      s3_pan_ff     <= s3_pan_in;
      s3_contrib_ff <= s3_contrib_in;
      acc_left_ff   <= acc_left_in;
      acc_right_ff  <= acc_right_in;
      out_left_ff   <= out_left_in;
      out_right_ff  <= out_right_in;
   end

   assign rsp_out_left  = out_left_ff;
   assign rsp_out_right = out_right_ff;

   `RSVM_ASSERT_NEXT(a_silent_without_setup, clock, reset, (cmd.issue && !present_ff), !s1_play_ff, "voice played before any voice setup")
   `RSVM_ASSERT_NOW(a_mix_only_from_issue, clock, reset, s3_play_ff, ($past(cmd.issue, 3) && $past(s1_play_ff, 2)), "mix stage active without an issued voice")

endmodule

// ===== sv/rhythm_sample_voice_mixer.sv =====
// Top level of the six-voice drum sample playback mixer.
// Request channel (req_valid/req_ready) carries one beat per item: a rhythm
// register write, an output tick, a sample memory write or a voice setup,
// chosen by req_kind. Register writes, memory writes and setups take effect
// in the cycle they are accepted and give no response; the block stays ready
// for the next beat. An output tick produces one response beat
// (rsp_valid/rsp_ready) with the mixed stereo pair. The six voices enter a
// four-stage fetch, scale and mix pipeline one per cycle; a tick runs through
// the issue of the six voices, the drain of the pipeline and the load of the
// output register before rsp_valid rises. While a tick runs, req_ready is
// low, so no new beat is taken until the tick has finished.
// The result sits in an output register; a new request beat is taken while
// it waits. If the receiver stalls, the next tick finishes its work and then
// holds until the previous result is taken.
// Reset clears key mask, levels, pans and voice setup, and puts every voice
// at its idle position. Sample memory is not cleared and must be written
// before a keyed voice reads it.
module rhythm_sample_voice_mixer #(
   parameter int VOICE_SAMPLES = 65536,
   parameter int FRACTION_BITS = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [7:0]         req_reg_addr,
   input  logic [7:0]         req_reg_data,
   input  logic [2:0]         req_voice,
   input  logic [15:0]        req_mem_addr,
   input  logic signed [15:0] req_mem_sample,
   input  logic [16:0]        req_voice_length,
   input  logic [15:0]        req_voice_step,
   input  logic signed [7:0]  req_voice_volume,
   input  logic signed [15:0] req_in_left,
   input  logic signed [15:0] req_in_right,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_out_left,
   output logic signed [15:0] rsp_out_right
);

   rsvm_pkg::rsvm_cmd_type cmd;

   // Sequencing of beats and voices.
   rsvm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Voice state, sample memory and mixing pipeline.
   rsvm_datapath #(
      .VOICE_SAMPLES (VOICE_SAMPLES),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_kind         (req_kind),
      .req_reg_addr     (req_reg_addr),
      .req_reg_data     (req_reg_data),
      .req_voice        (req_voice),
      .req_mem_addr     (req_mem_addr),
      .req_mem_sample   (req_mem_sample),
      .req_voice_length (req_voice_length),
      .req_voice_step   (req_voice_step),
      .req_voice_volume (req_voice_volume),
      .req_in_left      (req_in_left),
      .req_in_right     (req_in_right),
      .rsp_out_left     (rsp_out_left),
      .rsp_out_right    (rsp_out_right)
   );

endmodule

// ===== dv/rsvm_mix_checker.sv =====
// Checker for the drum voice mixer: tracks voice state, predicts each mixed pair and compares.
`timescale 1ns / 1ps

module rsvm_mix_checker #(
   parameter int VOICE_SAMPLES = 65536,
   parameter int FRACTION_BITS = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [7:0]         req_reg_addr,
   input  logic [7:0]         req_reg_data,
   input  logic [2:0]         req_voice,
   input  logic [15:0]        req_mem_addr,
   input  logic signed [15:0] req_mem_sample,
   input  logic [16:0]        req_voice_length,
   input  logic [15:0]        req_voice_step,
   input  logic signed [7:0]  req_voice_volume,
   input  logic signed [15:0] req_in_left,
   input  logic signed [15:0] req_in_right,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_out_left,
   input  logic signed [15:0] rsp_out_right,
   output int                 failures,
   output int                 pending
);

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
   } stereo_pair_type;

   // Shadow copy of the mixer's voice and register state.
   logic [5:0]         keys;
   logic [5:0]         master_atten;
   logic [1:0]         pan [rsvm_pkg::NVOICES];
   logic [4:0]         level_atten [rsvm_pkg::NVOICES];
   logic signed [7:0]  vol_offset [rsvm_pkg::NVOICES];
   logic [31:0]        play_pos [rsvm_pkg::NVOICES];
   logic [31:0]        play_end [rsvm_pkg::NVOICES];
   logic [15:0]        play_step [rsvm_pkg::NVOICES];
   bit                 loaded;
   int                 gain_lut [rsvm_pkg::GAIN_ENTRIES];
   logic signed [15:0] pcm_mem [int];
   stereo_pair_type    expected_mix [$];

   // Attenuation table: 2^((128 - db) / 8), scaled down by 2^4, minus the one LSB offset.
   initial begin
      longint unsigned root_step [8];
      longint unsigned x;
      int              t;
      root_step[0] = 64'd4294967296;
      root_step[1] = 64'd4683695047;
      root_step[2] = 64'd5107605667;
      root_step[3] = 64'd5569883475;
      root_step[4] = 64'd6074000999;
      root_step[5] = 64'd6623744058;
      root_step[6] = 64'd7223245205;
      root_step[7] = 64'd7877004751;
      failures = 0;
      pending = 0;
      for (int i = 0; i < rsvm_pkg::GAIN_ENTRIES; i++) begin
         t = 128 - (i + rsvm_pkg::DB_MIN);
         x = (root_step[t % 8] << (t / 8)) >> 32;
         gain_lut[i] = int'((x - 64'd1) >> 4);
      end
   end

   function automatic logic signed [15:0] clip16(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return -16'sh8000;
      return v[15:0];
   endfunction

   // Rhythm register write: key on or dump, total level, per-voice pan and level.
   function automatic void write_rhythm_reg(input logic [7:0] addr, input logic [7:0] data);
      if (addr == rsvm_pkg::ADDR_KEY) begin
         if (!data[7]) begin
            keys = keys | data[5:0];
            for (int i = 0; i < rsvm_pkg::NVOICES; i++)
               if (data[i]) play_pos[i] = '0;
         end else begin
            keys = keys & ~data[5:0];
         end
      end else if (addr == rsvm_pkg::ADDR_TOTAL) begin
         master_atten = ~data[5:0];
      end else if (addr >= rsvm_pkg::ADDR_PAN_BASE &&
                   addr <= rsvm_pkg::ADDR_PAN_BASE + rsvm_pkg::NVOICES - 1) begin
         pan[addr[2:0]] = data[7:6];
         level_atten[addr[2:0]] = ~data[4:0];
      end
   endfunction

   // One output tick: add every playing voice into the incoming pair, saturating each time.
   function automatic stereo_pair_type mix_tick_pair(input logic signed [15:0] in_l,
                                                     input logic signed [15:0] in_r);
      stereo_pair_type    pair;
      longint             acc_l;
      longint             acc_r;
      longint             part;
      logic signed [15:0] pcm;
      int                 db;
      int                 idx;
      acc_l = in_l;
      acc_r = in_r;
      if (loaded) begin
         for (int i = 0; i < rsvm_pkg::NVOICES; i++) begin
            if (keys[i] && play_pos[i] < play_end[i]) begin
               db = int'(master_atten) + int'(level_atten[i]) + int'(vol_offset[i]);
               if (db > rsvm_pkg::DB_MAX) db = rsvm_pkg::DB_MAX;
               if (db < rsvm_pkg::DB_MIN) db = rsvm_pkg::DB_MIN;
               idx = int'(play_pos[i] >> FRACTION_BITS);
               if (idx >= VOICE_SAMPLES) idx = VOICE_SAMPLES - 1;
               pcm = pcm_mem.exists(i * VOICE_SAMPLES + idx) ?
                     pcm_mem[i * VOICE_SAMPLES + idx] : 16'sd0;
               part = (longint'(pcm) * longint'(gain_lut[db - rsvm_pkg::DB_MIN])) >>> 12;
               play_pos[i] = play_pos[i] + play_step[i];
               if (pan[i][1]) acc_l = clip16(acc_l + part);
               if (pan[i][0]) acc_r = clip16(acc_r + part);
            end
         end
      end
      pair.left = acc_l[15:0];
      pair.right = acc_r[15:0];
      return pair;
   endfunction

   // Response beats first (they belong to older ticks), then the request beat.
   always @(posedge clock) begin
      stereo_pair_type want;
      logic [16:0]     len;
      if (reset) begin
         keys = '0;
         master_atten = '0;
         loaded = 1'b0;
         for (int i = 0; i < rsvm_pkg::NVOICES; i++) begin
            pan[i] = '0;
            level_atten[i] = '0;
            vol_offset[i] = '0;
            play_pos[i] = '1;
            play_end[i] = '0;
            play_step[i] = '0;
         end
         expected_mix.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_mix.size() == 0) begin
               $display("%0t: unexpected response beat, expected none, got left %0d right %0d",
                        $time, rsp_out_left, rsp_out_right);
               failures++;
            end else begin
               want = expected_mix.pop_front();
               if (rsp_out_left !== want.left) begin
                  $display("%0t: out_left expected %0d got %0d", $time, want.left, rsp_out_left);
                  failures++;
               end
               if (rsp_out_right !== want.right) begin
                  $display("%0t: out_right expected %0d got %0d",
                           $time, want.right, rsp_out_right);
                  failures++;
               end
            end
         end

         if (req_valid && req_ready) begin
            case (req_kind)
               rsvm_pkg::KIND_REG: write_rhythm_reg(req_reg_addr, req_reg_data);
               rsvm_pkg::KIND_TICK:
                  expected_mix.push_back(mix_tick_pair(req_in_left, req_in_right));
               rsvm_pkg::KIND_MEM: begin
                  if (req_voice < rsvm_pkg::NVOICES && int'(req_mem_addr) < VOICE_SAMPLES)
                     pcm_mem[int'(req_voice) * VOICE_SAMPLES + int'(req_mem_addr)] =
                        req_mem_sample;
               end
               rsvm_pkg::KIND_SETUP: begin
                  if (req_voice < rsvm_pkg::NVOICES) begin
                     len = (req_voice_length > VOICE_SAMPLES) ?
                           17'(VOICE_SAMPLES) : req_voice_length;
                     play_end[req_voice] = 32'(len) << FRACTION_BITS;
                     play_step[req_voice] = req_voice_step;
                     vol_offset[req_voice] = req_voice_volume;
                     loaded = 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end
      pending = expected_mix.size();
   end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the drum voice mixer: clock, reset, request and response drivers, verdict.
`timescale 1ns / 1ps

module tb;

   localparam int VOICE_SAMPLES = 65536;
   localparam int FRACTION_BITS = 10;
   localparam int RANDOM_BEATS  = 1630;
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT   = 500000;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         reg_addr;
      logic [7:0]         reg_data;
      logic [2:0]         voice;
      logic [15:0]        mem_addr;
      logic signed [15:0] mem_sample;
      logic [16:0]        voice_length;
      logic [15:0]        voice_step;
      logic signed [7:0]  voice_volume;
      logic signed [15:0] in_left;
      logic signed [15:0] in_right;
   } mixer_beat_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_kind;
   logic [7:0]         req_reg_addr;
   logic [7:0]         req_reg_data;
   logic [2:0]         req_voice;
   logic [15:0]        req_mem_addr;
   logic signed [15:0] req_mem_sample;
   logic [16:0]        req_voice_length;
   logic [15:0]        req_voice_step;
   logic signed [7:0]  req_voice_volume;
   logic signed [15:0] req_in_left;
   logic signed [15:0] req_in_right;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_out_left;
   logic signed [15:0] rsp_out_right;
   int                 failures;
   int                 pending;

   // Sample memory written so far, and the written run from address 0 of each voice.
   // In the random phase a voice 0 to 5 is only set up with a length inside that run.
   bit filled [rsvm_pkg::NVOICES][VOICE_SAMPLES];
   int prefix [rsvm_pkg::NVOICES];
   bit steady = 1'b0;
   int cycles = 0;
   int stall_left = 0;

   rhythm_sample_voice_mixer #(
      .VOICE_SAMPLES(VOICE_SAMPLES),
      .FRACTION_BITS(FRACTION_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_reg_addr(req_reg_addr),
      .req_reg_data(req_reg_data),
      .req_voice(req_voice),
      .req_mem_addr(req_mem_addr),
      .req_mem_sample(req_mem_sample),
      .req_voice_length(req_voice_length),
      .req_voice_step(req_voice_step),
      .req_voice_volume(req_voice_volume),
      .req_in_left(req_in_left),
      .req_in_right(req_in_right),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_left(rsp_out_left),
      .rsp_out_right(rsp_out_right)
   );

   rsvm_mix_checker #(
      .VOICE_SAMPLES(VOICE_SAMPLES),
      .FRACTION_BITS(FRACTION_BITS)
   ) mix_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_reg_addr(req_reg_addr),
      .req_reg_data(req_reg_data),
      .req_voice(req_voice),
      .req_mem_addr(req_mem_addr),
      .req_mem_sample(req_mem_sample),
      .req_voice_length(req_voice_length),
      .req_voice_step(req_voice_step),
      .req_voice_volume(req_voice_volume),
      .req_in_left(req_in_left),
      .req_in_right(req_in_right),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_left(rsp_out_left),
      .rsp_out_right(rsp_out_right),
      .failures(failures),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // Receiver: short stall bursts, none while the steady stretch runs.
   initial rsp_ready = 1'b0;
   always @(negedge clock) begin
      if (stall_left != 0)
         stall_left <= stall_left - 1;
      else if ($urandom_range(0, 99) < 4)
         stall_left <= $urandom_range(1, 5);
      rsp_ready <= steady || (stall_left == 0);
   end

   // Every field random; the beat builders below override the ones that matter.
   function automatic mixer_beat_type noise_beat(input logic [1:0] kind);
      mixer_beat_type b;
      b.kind = kind;
      b.reg_addr = $urandom;
      b.reg_data = $urandom;
      b.voice = $urandom_range(0, 7);
      b.mem_addr = $urandom;
      b.mem_sample = $urandom;
      b.voice_length = $urandom;
      b.voice_step = $urandom;
      b.voice_volume = $urandom;
      b.in_left = $urandom;
      b.in_right = $urandom;
      return b;
   endfunction

   function automatic mixer_beat_type reg_beat(input logic [7:0] addr, input logic [7:0] data);
      mixer_beat_type b;
      b = noise_beat(rsvm_pkg::KIND_REG);
      b.reg_addr = addr;
      b.reg_data = data;
      return b;
   endfunction

   function automatic mixer_beat_type tick_beat(input logic signed [15:0] l,
                                                input logic signed [15:0] r);
      mixer_beat_type b;
      b = noise_beat(rsvm_pkg::KIND_TICK);
      b.in_left = l;
      b.in_right = r;
      return b;
   endfunction

   function automatic mixer_beat_type mem_beat(input logic [2:0] v, input logic [15:0] a,
                                               input logic signed [15:0] s);
      mixer_beat_type b;
      b = noise_beat(rsvm_pkg::KIND_MEM);
      b.voice = v;
      b.mem_addr = a;
      b.mem_sample = s;
      return b;
   endfunction

   function automatic mixer_beat_type setup_beat(input logic [2:0] v, input logic [16:0] len,
                                                 input logic [15:0] step,
                                                 input logic signed [7:0] vol);
      mixer_beat_type b;
      b = noise_beat(rsvm_pkg::KIND_SETUP);
      b.voice = v;
      b.voice_length = len;
      b.voice_step = step;
      b.voice_volume = vol;
      return b;
   endfunction

   // Present one beat, hold it until accepted, and note any sample memory it fills.
   task automatic send_beat(input mixer_beat_type b);
      int gap;
      if (!steady && $urandom_range(0, 99) < 10) begin
         gap = $urandom_range(1, 14);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_kind = b.kind;
      req_reg_addr = b.reg_addr;
      req_reg_data = b.reg_data;
      req_voice = b.voice;
      req_mem_addr = b.mem_addr;
      req_mem_sample = b.mem_sample;
      req_voice_length = b.voice_length;
      req_voice_step = b.voice_step;
      req_voice_volume = b.voice_volume;
      req_in_left = b.in_left;
      req_in_right = b.in_right;
      do @(posedge clock); while (!req_ready);
      if (b.kind == rsvm_pkg::KIND_MEM && b.voice < rsvm_pkg::NVOICES) begin
         filled[b.voice][b.mem_addr] = 1'b1;
         while (prefix[b.voice] < VOICE_SAMPLES && filled[b.voice][prefix[b.voice]])
            prefix[b.voice]++;
      end
      @(negedge clock);
   endtask

   initial begin
      mixer_beat_type b;
      int             pick;
      int             v;
      logic [15:0]    step;
      logic [7:0]     data;

      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = rsvm_pkg::KIND_REG;
      req_reg_addr = '0;
      req_reg_data = '0;
      req_voice = '0;
      req_mem_addr = '0;
      req_mem_sample = '0;
      req_voice_length = '0;
      req_voice_step = '0;
      req_voice_volume = '0;
      req_in_left = '0;
      req_in_right = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: pass-through before any setup, ignored voices, loudest voice with
      // saturation, end of sample, saturated length, full attenuation, dump, stray address.
      send_beat(tick_beat(16'sh7fff, -16'sh8000));
      send_beat(mem_beat(3'd0, 16'd0, -16'sh8000));
      send_beat(mem_beat(3'd0, 16'd1, 16'sh7fff));
      send_beat(mem_beat(3'd1, 16'd0, 16'sh7fff));
      send_beat(mem_beat(3'd7, 16'hffff, 16'sh1234));
      send_beat(mem_beat(3'd2, 16'hffff, -16'sd1));
      send_beat(setup_beat(3'd6, 17'h1ffff, 16'hffff, 8'sd127));
      send_beat(tick_beat(16'sd100, -16'sd100));
      send_beat(setup_beat(3'd0, 17'd2, 16'd1024, -8'sd13));
      send_beat(reg_beat(rsvm_pkg::ADDR_TOTAL, 8'h3f));
      send_beat(reg_beat(rsvm_pkg::ADDR_PAN_BASE, 8'hdf));
      send_beat(reg_beat(rsvm_pkg::ADDR_KEY, 8'h41));
      send_beat(tick_beat(16'sh7fff, -16'sh8000));
      send_beat(tick_beat(-16'sh8000, 16'sh7fff));
      send_beat(tick_beat(16'sd0, 16'sd0));
      send_beat(setup_beat(3'd1, 17'h1ffff, 16'd0, 8'sd127));
      send_beat(reg_beat(rsvm_pkg::ADDR_PAN_BASE + 8'd1, 8'h40));
      send_beat(reg_beat(rsvm_pkg::ADDR_KEY, 8'h02));
      send_beat(tick_beat(16'sd0, 16'sd0));
      send_beat(reg_beat(rsvm_pkg::ADDR_TOTAL, 8'h00));
      send_beat(tick_beat(-16'sd1, 16'sd1));
      send_beat(reg_beat(rsvm_pkg::ADDR_KEY, 8'hff));
      send_beat(setup_beat(3'd1, 17'd1, 16'd0, 8'sd0));
      send_beat(reg_beat(8'h1e, 8'hff));
      send_beat(tick_beat(16'sd0, 16'sd0));

      // Random: samples loaded from address 0 up, voices set up inside what is loaded,
      // keyed, panned and ticked; a share of stray addresses and ignored voices.
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         steady = (n >= 700 && n < 1000);
         pick = $urandom_range(0, 99);
         v = $urandom_range(0, rsvm_pkg::NVOICES - 1);
         if (pick < 30) begin
            b = tick_beat($urandom, $urandom);
            if ($urandom_range(0, 4) == 0) begin
               b.in_left = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
               b.in_right = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
            end
         end else if (pick < 55) begin
            if ($urandom_range(0, 9) < 8 && prefix[v] < VOICE_SAMPLES)
               b = mem_beat(v, prefix[v], $urandom);
            else
               b = mem_beat($urandom_range(0, 7), $urandom, $urandom);
            if ($urandom_range(0, 9) == 0)
               b.mem_sample = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
         end else if (pick < 65) begin
            if ($urandom_range(0, 9) == 0) begin
               b = setup_beat($urandom_range(6, 7), $urandom, $urandom, $urandom);
            end else begin
               step = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2047) : $urandom;
               b = setup_beat(v, $urandom_range(0, prefix[v]), step,
                              $urandom_range(0, 140) - 13);
            end
         end else if (pick < 80) begin
            data = $urandom;
            data[7] = ($urandom_range(0, 9) >= 6);
            b = reg_beat(rsvm_pkg::ADDR_KEY, data);
         end else if (pick < 90) begin
            b = reg_beat(rsvm_pkg::ADDR_PAN_BASE +
                         8'($urandom_range(0, rsvm_pkg::NVOICES - 1)), $urandom);
         end else if (pick < 95) begin
            b = reg_beat(rsvm_pkg::ADDR_TOTAL, $urandom);
         end else begin
            b = reg_beat($urandom, $urandom);
         end
         send_beat(b);
      end
      steady = 1'b0;
      req_valid = 1'b0;

      // Drain outstanding pairs, then watch a little longer for stray beats.
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (failures == 0 && pending == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
